[src/feal4_pkg.sv]
package feal4_pkg;

	localparam int BLOCK_W = 64;
	localparam int WORD_W = 32;
	localparam int NUM_ROUNDS = 4;
	localparam int NUM_KEYS = 6;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_SUBKEY_0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SUBKEY_1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SUBKEY_2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SUBKEY_3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WHITEN_L = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WHITEN_R = 3'd5;

	localparam logic MODE_ENCRYPT = 1'b0;
	localparam logic MODE_DECRYPT = 1'b1;

	// Both directions run the same round on a pair (p, q):
	// p' = q ^ F(p ^ k), q' = p. Encryption keeps p = right, q = left;
	// decryption keeps p = left, q = right.
	typedef struct packed {
		logic              mode;
		logic [WORD_W-1:0] p;
		logic [WORD_W-1:0] q;
	} stage_t;

	function automatic logic [7:0] mix_g(input logic [7:0] a, input logic [7:0] b,
		input logic extra);
		logic [7:0] s;
		begin
			s = a + b + {7'd0, extra};
			mix_g = {s[5:0], s[7:6]};
		end
	endfunction

	function automatic logic [WORD_W-1:0] round_fn(input logic [WORD_W-1:0] w);
		logic [7:0] b0, b1, b2, b3, o0, o1, o2, o3;
		begin
			b0 = w[31:24];
			b1 = w[23:16];
			b2 = w[15:8];
			b3 = w[7:0];
			o1 = mix_g(b1 ^ b0, b2 ^ b3, 1'b1);
			o0 = mix_g(b0, o1, 1'b0);
			o2 = mix_g(o1, b2 ^ b3, 1'b0);
			o3 = mix_g(o2, b3, 1'b1);
			round_fn = {o0, o1, o2, o3};
		end
	endfunction

endpackage

[src/feal4_if.sv]
interface feal4_in_if;
	import feal4_pkg::*;
	logic               valid;
	logic               ready;
	logic               mode;
	logic [BLOCK_W-1:0] block_in;
	modport source(output valid, output mode, output block_in, input ready);
	modport sink(input valid, input mode, input block_in, output ready);
endinterface

interface feal4_out_if;
	import feal4_pkg::*;
	logic               valid;
	logic               ready;
	logic [BLOCK_W-1:0] block_out;
	modport source(output valid, output block_out, input ready);
	modport sink(input valid, input block_out, output ready);
endinterface

interface feal4_cfg_if;
	import feal4_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [WORD_W-1:0]    data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

[src/feal4_block_cipher_core.sv]
// Pipeline: an accepted request passes through four round cells and then one output whitening
// register, which offers the result on the output port.
// Throughput: one block per cycle; a full cell stalls only while its successor is not ready.
// Reset (arst_n low) clears all six key registers to zero and empties the pipeline.
// The configuration port is always ready; write keys only while no block is in flight.
module feal4_block_cipher_core (
	input  logic       clk,
	input  logic       arst_n,
	feal4_in_if.sink   src,
	feal4_out_if.source dst,
	feal4_cfg_if.sink  cfg
);
	import feal4_pkg::*;

	logic [WORD_W-1:0] key_q [NUM_KEYS];

	stage_t            entry_data;
	logic [WORD_W-1:0] hi, lo, dec_r;

	logic   cell_valid [NUM_ROUNDS+1];
	logic   cell_ready [NUM_ROUNDS+1];
	stage_t cell_data  [NUM_ROUNDS+1];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_KEYS; i++) begin
				key_q[i] <= '0;
			end
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_SUBKEY_0: key_q[0] <= cfg.data;
				REG_SUBKEY_1: key_q[1] <= cfg.data;
				REG_SUBKEY_2: key_q[2] <= cfg.data;
				REG_SUBKEY_3: key_q[3] <= cfg.data;
				REG_WHITEN_L: key_q[4] <= cfg.data;
				REG_WHITEN_R: key_q[5] <= cfg.data;
				default: ;
			endcase
		end
	end

	// Input whitening: encryption folds the left half into the right one,
	// decryption strips the output whitening first.
	assign hi    = src.block_in[BLOCK_W-1:WORD_W];
	assign lo    = src.block_in[WORD_W-1:0];
	assign dec_r = hi ^ key_q[4];

	always_comb begin
		entry_data.mode = src.mode;
		if (src.mode == MODE_DECRYPT) begin
			entry_data.p = dec_r ^ lo ^ key_q[5];
			entry_data.q = dec_r;
		end else begin
			entry_data.p = hi ^ lo;
			entry_data.q = hi;
		end
	end

	assign cell_valid[0] = src.valid;
	assign cell_data[0]  = entry_data;
	assign src.ready     = cell_ready[0];

	for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_cell
		feal4_round_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (cell_valid[g]),
			.in_ready  (cell_ready[g]),
			.in_data   (cell_data[g]),
			.key_enc   (key_q[g]),
			.key_dec   (key_q[NUM_ROUNDS-1-g]),
			.out_valid (cell_valid[g+1]),
			.out_ready (cell_ready[g+1]),
			.out_data  (cell_data[g+1])
		);
	end

	feal4_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cell_valid[NUM_ROUNDS]),
		.in_ready (cell_ready[NUM_ROUNDS]),
		.in_data  (cell_data[NUM_ROUNDS]),
		.whiten_l (key_q[4]),
		.whiten_r (key_q[5]),
		.dst      (dst)
	);

	a_accept_fills_first_cell: assert property (@(posedge clk) disable iff (!arst_n)
		src.valid && src.ready |=> cell_valid[1])
		else $error("accepted request did not reach the first round cell");

	a_last_cell_holds: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid[NUM_ROUNDS] && !cell_ready[NUM_ROUNDS] |=>
		cell_valid[NUM_ROUNDS] && $stable(cell_data[NUM_ROUNDS]))
		else $error("last round cell lost its block while stalled");

	a_drain_to_output: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid[NUM_ROUNDS] && !dst.valid |=> dst.valid)
		else $error("output register did not load from the last round cell");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!cell_valid[1] |-> src.ready)
		else $error("input stalled while the first round cell is empty");

endmodule

[src/feal4_round_cell.sv]
module feal4_round_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  feal4_pkg::stage_t           in_data,
	input  logic [feal4_pkg::WORD_W-1:0] key_enc,
	input  logic [feal4_pkg::WORD_W-1:0] key_dec,
	output logic                        out_valid,
	input  logic                        out_ready,
	output feal4_pkg::stage_t           out_data
);
	import feal4_pkg::*;

	logic              valid_q;
	stage_t            data_q;
	stage_t            next_data;
	logic [WORD_W-1:0] key;

	assign in_ready = !valid_q || out_ready;
	assign key = (in_data.mode == MODE_DECRYPT) ? key_dec : key_enc;

	always_comb begin
		next_data.mode = in_data.mode;
		next_data.p    = in_data.q ^ round_fn(in_data.p ^ key);
		next_data.q    = in_data.p;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= next_data;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

[src/feal4_out_stage.sv]
module feal4_out_stage (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  feal4_pkg::stage_t           in_data,
	input  logic [feal4_pkg::WORD_W-1:0] whiten_l,
	input  logic [feal4_pkg::WORD_W-1:0] whiten_r,
	feal4_out_if.source                 dst
);
	import feal4_pkg::*;

	logic               valid_q;
	logic [BLOCK_W-1:0] block_q;
	logic [BLOCK_W-1:0] next_block;

	assign in_ready = !valid_q || dst.ready;

	always_comb begin
		if (in_data.mode == MODE_DECRYPT) begin
			next_block = {in_data.p, in_data.q ^ in_data.p};
		end else begin
			next_block = {in_data.p ^ whiten_l, in_data.q ^ in_data.p ^ whiten_r};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			block_q <= next_block;
		end
	end

	assign dst.valid     = valid_q;
	assign dst.block_out = block_q;

endmodule

[verif/feal4_block_cipher_core_tb.sv]
`timescale 1ns / 100ps

module feal4_block_cipher_core_tb;
	import feal4_pkg::*;

	// Register indexes past the key list; writes to them must not change anything.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	localparam int NUM_PHASES = 8;
	localparam int PHASE_ITEMS = 243;
	localparam int SETTLE_CYCLES = 12;
	localparam int LONG_HOLD = 160;
	localparam int STALL_LIMIT = 3000;

	typedef struct packed {
		logic               mode;
		logic [BLOCK_W-1:0] blk;
	} cipher_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	feal4_in_if  in_ch ();
	feal4_out_if out_ch ();
	feal4_cfg_if cfg_ch ();

	feal4_block_cipher_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.src(in_ch),
		.dst(out_ch),
		.cfg(cfg_ch)
	);

	cipher_req_t        req_q[$];
	logic [BLOCK_W-1:0] expected_q[$];
	logic [WORD_W-1:0]  key_model [NUM_KEYS];

	cipher_req_t        next_req;
	logic [BLOCK_W-1:0] expected_blk;
	logic               req_taken = 1'b0;
	logic               any_taken;
	int                 n_offered = 0;
	int                 n_accepted = 0;
	int                 mismatches = 0;
	int                 idle_cycles = 0;
	int                 src_gap_pct = 0;
	int                 dst_stall_pct = 0;
	int                 hold_requests = 0;
	int                 holds_served = 0;
	int                 hold_cnt = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [7:0] byte_mix(input logic [7:0] a, input logic [7:0] b,
		input logic carry_in);
		logic [7:0] s;
		s = a + b + {7'd0, carry_in};
		return {s[5:0], s[7:6]};
	endfunction

	function automatic logic [WORD_W-1:0] feal_f(input logic [WORD_W-1:0] w);
		logic [7:0] c1, c0, c2, c3, x23;
		x23 = w[15:8] ^ w[7:0];
		c1 = byte_mix(w[23:16] ^ w[31:24], x23, 1'b1);
		c0 = byte_mix(w[31:24], c1, 1'b0);
		c2 = byte_mix(c1, x23, 1'b0);
		c3 = byte_mix(c2, w[7:0], 1'b1);
		return {c0, c1, c2, c3};
	endfunction

	function automatic logic [BLOCK_W-1:0] cipher_predict(input logic mode,
		input logic [BLOCK_W-1:0] blk);
		logic [WORD_W-1:0] lh, rh, tmp;
		int i;
		if (mode == MODE_ENCRYPT) begin
			lh = blk[63:32];
			rh = lh ^ blk[31:0];
			for (i = 0; i < NUM_ROUNDS; i++) begin
				tmp = rh;
				rh = lh ^ feal_f(rh ^ key_model[i]);
				lh = tmp;
			end
			return {rh ^ key_model[4], lh ^ rh ^ key_model[5]};
		end else begin
			rh = blk[63:32] ^ key_model[4];
			lh = rh ^ blk[31:0] ^ key_model[5];
			for (i = 0; i < NUM_ROUNDS; i++) begin
				tmp = lh;
				lh = rh ^ feal_f(lh ^ key_model[NUM_ROUNDS - 1 - i]);
				rh = tmp;
			end
			return {lh, rh ^ lh};
		end
	endfunction

	function automatic logic [CFG_IDX_W-1:0] key_reg(input int k);
		case (k)
			0: return REG_SUBKEY_0;
			1: return REG_SUBKEY_1;
			2: return REG_SUBKEY_2;
			3: return REG_SUBKEY_3;
			4: return REG_WHITEN_L;
			default: return REG_WHITEN_R;
		endcase
	endfunction

	// Bytes near the carry boundaries of the 8-bit additions are mixed in often.
	function automatic logic [BLOCK_W-1:0] rand_block();
		logic [BLOCK_W-1:0] b;
		int i;
		b = {$urandom, $urandom};
		if ($urandom_range(3) == 0) begin
			for (i = 0; i < 8; i++) begin
				case ($urandom_range(4))
					0: b[i*8 +: 8] = 8'h00;
					1: b[i*8 +: 8] = 8'hFF;
					2: b[i*8 +: 8] = 8'h80;
					3: b[i*8 +: 8] = 8'h01;
					default: ;
				endcase
			end
		end
		return b;
	endfunction

	function automatic logic [WORD_W-1:0] rand_key();
		case ($urandom_range(4))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic offer(input logic mode, input logic [BLOCK_W-1:0] blk);
		cipher_req_t r;
		r.mode = mode;
		r.blk = blk;
		req_q.push_back(r);
		n_offered++;
	endtask

	task automatic drain();
		while (n_accepted != n_offered || expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Sender: a new request goes out once the previous one has been taken.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.mode <= MODE_ENCRYPT;
			in_ch.block_in <= '0;
		end else if (!in_ch.valid || req_taken) begin
			if (req_q.size() != 0 && $urandom_range(99) >= src_gap_pct) begin
				next_req = req_q.pop_front();
				in_ch.valid <= 1'b1;
				in_ch.mode <= next_req.mode;
				in_ch.block_in <= next_req.blk;
			end else
				in_ch.valid <= 1'b0;
		end
	end

	// Receiver: random stalls, plus a long hold-off whenever one is requested.
	always @(negedge clk) begin
		if (hold_requests != holds_served) begin
			out_ch.ready <= 1'b0;
			if (hold_cnt == LONG_HOLD - 1) begin
				hold_cnt <= 0;
				holds_served <= holds_served + 1;
			end else
				hold_cnt <= hold_cnt + 1;
		end else
			out_ch.ready <= ($urandom_range(99) >= dst_stall_pct);
	end

	always @(posedge clk) begin
		any_taken = 1'b0;
		req_taken <= in_ch.valid && in_ch.ready;
		if (!arst_n) begin
			for (int k = 0; k < NUM_KEYS; k++)
				key_model[k] = '0;
		end
		if (cfg_ch.valid && cfg_ch.ready) begin
			any_taken = 1'b1;
			if (cfg_ch.index < NUM_KEYS)
				key_model[cfg_ch.index] = cfg_ch.data;
		end
		if (in_ch.valid && in_ch.ready) begin
			any_taken = 1'b1;
			expected_q.push_back(cipher_predict(in_ch.mode, in_ch.block_in));
			n_accepted <= n_accepted + 1;
		end
		if (out_ch.valid && out_ch.ready) begin
			any_taken = 1'b1;
			if (expected_q.size() == 0) begin
				$error("block_out: no result expected, actual %h", out_ch.block_out);
				mismatches <= mismatches + 1;
			end else begin
				expected_blk = expected_q.pop_front();
				if (out_ch.block_out !== expected_blk) begin
					$error("block_out: expected %h, actual %h", expected_blk, out_ch.block_out);
					mismatches <= mismatches + 1;
				end
			end
		end
		if (any_taken)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= STALL_LIMIT);
		$display("feal4_block_cipher_core_tb NOT OK");
		$finish;
	end

	initial begin
		logic [BLOCK_W-1:0] corner [4];
		int i, ph, k, n;
		corner[0] = 64'h0000_0000_0000_0000;
		corner[1] = 64'hFFFF_FFFF_FFFF_FFFF;
		corner[2] = 64'h0123_4567_89AB_CDEF;
		corner[3] = 64'h8000_0000_0000_0001;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_SUBKEY_0;
		cfg_ch.data = '0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Keys still at their reset value of zero.
		for (i = 0; i < 4; i++) begin
			offer(MODE_ENCRYPT, corner[i]);
			offer(MODE_DECRYPT, corner[i]);
		end
		drain();

		for (k = 0; k < NUM_KEYS; k++)
			write_reg(key_reg(k), '1);
		write_reg(REG_SPARE_6, 32'h1234_5678);
		write_reg(REG_SPARE_7, '1);
		offer(MODE_ENCRYPT, corner[0]);
		offer(MODE_DECRYPT, corner[0]);
		offer(MODE_ENCRYPT, corner[1]);
		offer(MODE_DECRYPT, corner[1]);
		drain();

		for (k = 0; k < NUM_KEYS; k++)
			write_reg(key_reg(k), 32'h0123_4567 + k * 32'h1111_1111);
		offer(MODE_ENCRYPT, corner[2]);
		offer(MODE_DECRYPT, corner[2]);
		offer(MODE_ENCRYPT, corner[3]);
		offer(MODE_DECRYPT, corner[3]);
		drain();

		for (ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph % 4)
				0: begin
					src_gap_pct = 0;
					dst_stall_pct = 0;
				end
				1: begin
					src_gap_pct = 50;
					dst_stall_pct = 0;
				end
				2: begin
					src_gap_pct = 0;
					dst_stall_pct = 50;
				end
				default: begin
					src_gap_pct = 27;
					dst_stall_pct = 27;
				end
			endcase

			for (k = 0; k < NUM_KEYS; k++) begin
				if (ph == 1)
					write_reg(key_reg(k), '1);
				else if (ph == 2)
					write_reg(key_reg(k), '0);
				else if (ph == 0 || $urandom_range(9) < 7)
					write_reg(key_reg(k), rand_key());
			end
			if (ph % 3 == 0)
				write_reg($urandom_range(1) ? REG_SPARE_7 : REG_SPARE_6, $urandom);

			// The receiver holds off while the sender keeps offering, so the
			// pipeline fills and back-pressures its input.
			if (ph == 4 || ph == 7)
				hold_requests++;

			n = $urandom_range(PHASE_ITEMS / 4, 3 * PHASE_ITEMS / 4);
			for (i = 0; i < n; i++)
				offer($urandom_range(1) ? MODE_DECRYPT : MODE_ENCRYPT, rand_block());
			drain();
			for (i = n; i < PHASE_ITEMS; i++)
				offer($urandom_range(1) ? MODE_DECRYPT : MODE_ENCRYPT, rand_block());
			drain();
		end

		if (mismatches == 0)
			$display("feal4_block_cipher_core_tb OK");
		else
			$display("feal4_block_cipher_core_tb NOT OK");
		$finish;
	end

endmodule
